// ----- rtl/core/btc_pkg.sv -----
// ============================================================================
// btc_pkg: shared types and helpers of the balanced ternary converter
// Digit codes, the link that runs between neighboring cells, the cell
// controls and the per-cell digit update.
// ============================================================================
`default_nettype none

package btc_pkg;

	// Number of digit cells and width of the binary input magnitude.
	localparam int MAX_TRITS = 21;
	localparam int MAG_W     = 32;

	// Length of the conversion phase, from the first bit at cell 0 until the last
	// cell has taken its final update: each cell starts in the cycle after its lower neighbor.
	localparam int CONV_CYCLES = MAG_W + MAX_TRITS - 1;
	localparam int CNT_W       = $clog2(CONV_CYCLES);
	localparam int REM_W       = $clog2(MAX_TRITS + 1);

	// Digit codes: zero, plus one, minus one (Z).
	typedef logic [1:0] trit_t;
	localparam trit_t TRIT_ZERO = 2'd0;
	localparam trit_t TRIT_POS  = 2'd1;
	localparam trit_t TRIT_NEG  = 2'd2;

	// What one cell hands to its upper neighbor every cycle.
	typedef struct packed {
		logic  en;
		trit_t carry;
	} link_t;

	// Controls that every cell sees.
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctl_t;

	// New digit and carry of one cell.
	typedef struct packed {
		trit_t digit;
		trit_t carry;
	} step_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_OUT
	} state_t;

	// One doubling step of a digit: 2*d + c, with the result brought back
	// into one digit and a carry of -1, 0 or +1.
	function automatic step_t cell_step(trit_t d, trit_t c);
		step_t r;
		unique case ({d, c})
			{TRIT_ZERO, TRIT_ZERO}: r = '{digit: TRIT_ZERO, carry: TRIT_ZERO};
			{TRIT_ZERO, TRIT_POS}:  r = '{digit: TRIT_POS,  carry: TRIT_ZERO};
			{TRIT_ZERO, TRIT_NEG}:  r = '{digit: TRIT_NEG,  carry: TRIT_ZERO};
			{TRIT_POS,  TRIT_ZERO}: r = '{digit: TRIT_NEG,  carry: TRIT_POS};
			{TRIT_POS,  TRIT_POS}:  r = '{digit: TRIT_ZERO, carry: TRIT_POS};
			{TRIT_POS,  TRIT_NEG}:  r = '{digit: TRIT_POS,  carry: TRIT_ZERO};
			{TRIT_NEG,  TRIT_ZERO}: r = '{digit: TRIT_POS,  carry: TRIT_NEG};
			{TRIT_NEG,  TRIT_NEG}:  r = '{digit: TRIT_ZERO, carry: TRIT_NEG};
			{TRIT_NEG,  TRIT_POS}:  r = '{digit: TRIT_NEG,  carry: TRIT_ZERO};
			default:                r = '{digit: TRIT_ZERO, carry: TRIT_ZERO};
		endcase
		return r;
	endfunction

	// Sign flip of one digit.
	function automatic trit_t trit_negate(trit_t d);
		trit_t r;
		unique case (d)
			TRIT_POS: r = TRIT_NEG;
			TRIT_NEG: r = TRIT_POS;
			default:  r = TRIT_ZERO;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/btc_cell.sv -----
// ============================================================================
// btc_cell: one balanced ternary digit cell
// Holds one digit. While enabled it doubles its digit and adds the carry
// from its lower neighbor, passing its own carry up in the following cycle. In
// the skip and output phases, when shifted, it takes the digit of its lower neighbor.
// ============================================================================
`default_nettype none

module btc_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire btc_pkg::cell_ctl_t ctl,
	input  wire btc_pkg::link_t     link_in,
	output btc_pkg::link_t          link_out,
	input  wire btc_pkg::trit_t     digit_in,
	output btc_pkg::trit_t          digit
);

	btc_pkg::trit_t digit_q;
	btc_pkg::link_t link_q;
	btc_pkg::step_t step;

	// Doubling step of the held digit.
	assign step = btc_pkg::cell_step(digit_q, link_in.carry);

	// Digit and link registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= btc_pkg::TRIT_ZERO;
			link_q  <= '0;
		end else if (ctl.clear) begin
			digit_q <= btc_pkg::TRIT_ZERO;
			link_q  <= '0;
		end else if (ctl.shift) begin
			digit_q <= digit_in;
			link_q  <= '0;
		end else begin
			link_q.en <= link_in.en;
			if (link_in.en) begin
				digit_q      <= step.digit;
				link_q.carry <= step.carry;
			end else begin
				link_q.carry <= btc_pkg::TRIT_ZERO;
			end
		end
	end

	assign link_out = link_q;
	assign digit    = digit_q;

endmodule

`default_nettype wire

// ----- rtl/core/balanced_ternary_converter_unit.sv -----
// ============================================================================
// balanced_ternary_converter_unit: signed integer to balanced ternary digits
// A row of digit cells builds the balanced ternary form of the magnitude,
// then the digits leave most significant first, one beat per digit.
// ============================================================================
// Usage:
//   The slave channel takes one 32-bit signed value per beat. The master
//   channel returns its balanced ternary digits, most significant first,
//   one beat per digit, with tlast on the least significant digit. Zero
//   gives a single 0 digit. Negative values give every digit negated.
//   Timing: the magnitude enters the cell row one bit per cycle, 32 bits,
//   and each of the 21 cells starts in the cycle after its lower neighbor.
//   Leading zero digits are then dropped at one per cycle (up to 20 of
//   them), and then the leading digit is found; the digits then leave at
//   one per cycle while the receiver holds tready high. The next value is
//   taken in the idle cycle after the last digit.
//   Reset clears the controller and the cells; no beat is pending after it.
//   When the receiver holds tready low, the current digit stays on the
//   master port and the cell row holds its contents.
// ============================================================================
`default_nettype none

module balanced_ternary_converter_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [1:0] trit, [7:2] zero
	output logic        m_tlast
);

	btc_pkg::state_t                    state_q;
	btc_pkg::state_t                    state_d;
	logic [btc_pkg::CNT_W-1:0]          cnt_q;
	logic [btc_pkg::REM_W-1:0]          rem_q;
	logic [btc_pkg::MAG_W-1:0]          mag_q;
	logic                               neg_q;
	logic                               in_acc;
	logic                               conv_done;
	logic                               skip;
	logic                               is_last;
	btc_pkg::cell_ctl_t                 ctl;
	btc_pkg::link_t                     link [0:btc_pkg::MAX_TRITS];
	btc_pkg::trit_t                     digit [0:btc_pkg::MAX_TRITS-1];
	btc_pkg::trit_t                     top;

	assign in_acc    = s_tvalid && s_tready;
	assign conv_done = (cnt_q == btc_pkg::CNT_W'(btc_pkg::CONV_CYCLES - 1));
	assign top       = digit[btc_pkg::MAX_TRITS-1];
	assign is_last   = (rem_q == btc_pkg::REM_W'(1));
	assign skip      = (top == btc_pkg::TRIT_ZERO) && !is_last;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btc_pkg::ST_IDLE: if (in_acc) state_d = btc_pkg::ST_CONV;
			btc_pkg::ST_CONV: if (conv_done) state_d = btc_pkg::ST_SKIP;
			btc_pkg::ST_SKIP: if (!skip) state_d = btc_pkg::ST_OUT;
			btc_pkg::ST_OUT:  if (m_tready && is_last) state_d = btc_pkg::ST_IDLE;
			default:          state_d = btc_pkg::ST_IDLE;
		endcase
	end

	// Handshake and cell controls.
	always_comb begin
		s_tready  = (state_q == btc_pkg::ST_IDLE);
		m_tvalid  = (state_q == btc_pkg::ST_OUT);
		ctl.clear = in_acc;
		ctl.shift = ((state_q == btc_pkg::ST_SKIP) && skip) ||
		            ((state_q == btc_pkg::ST_OUT) && m_tready && !is_last);
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btc_pkg::ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (state_q == btc_pkg::ST_CONV) begin
				cnt_q <= cnt_q + btc_pkg::CNT_W'(1);
			end
			if ((state_q == btc_pkg::ST_CONV) && conv_done) begin
				rem_q <= btc_pkg::REM_W'(btc_pkg::MAX_TRITS);
			end else if (ctl.shift) begin
				rem_q <= rem_q - btc_pkg::REM_W'(1);
			end
		end
	end

	// Magnitude and sign; the magnitude shifts out most significant bit first.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= s_tdata[31];
			mag_q <= s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
		end else if (state_q == btc_pkg::ST_CONV) begin
			mag_q <= {mag_q[btc_pkg::MAG_W-2:0], 1'b0};
		end
	end

	// Bit feed into the lowest cell.
	assign link[0].en    = (state_q == btc_pkg::ST_CONV) &&
	                       (cnt_q < btc_pkg::CNT_W'(btc_pkg::MAG_W));
	assign link[0].carry = mag_q[btc_pkg::MAG_W-1] ? btc_pkg::TRIT_POS : btc_pkg::TRIT_ZERO;

	// Row of digit cells, lowest digit first.
	for (genvar k = 0; k < btc_pkg::MAX_TRITS; k++) begin : g_cell
		btc_pkg::trit_t below;
		if (k == 0) begin : g_low
			assign below = btc_pkg::TRIT_ZERO;
		end else begin : g_up
			assign below = digit[k-1];
		end
		btc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.link_in  (link[k]),
			.link_out (link[k+1]),
			.digit_in (below),
			.digit    (digit[k])
		);
	end

	// Output beat from the top cell, negated for negative values.
	assign m_tdata = {6'd0, neg_q ? btc_pkg::trit_negate(top) : top};
	assign m_tlast = is_last;

endmodule

`default_nettype wire

// ----- sim/tb_balanced_ternary_converter_unit.sv -----
// ============================================================================
// tb_balanced_ternary_converter_unit: self-checking bench of the converter
// Values go in on the slave stream, digits come back on the master stream.
// A directed table comes first: zero, small values, powers of three, the
// digit-count boundaries and the range ends, then random values. Digits are
// checked in order against typed digits or a bench-side divide-by-three
// model. Both sides idle at random; one calm stretch, two drain pauses.
// ============================================================================

module tb_balanced_ternary_converter_unit;

	timeunit 1ns;
	timeprecision 1ps;

	// One stimulus row; n_typed > 0 means the digits are given in digs,
	// most significant digit in the highest used pair.
	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  n_typed;
		logic [7:0]  digs;
	} stim_row_t;

	// One expected digit beat.
	typedef struct packed {
		btc_pkg::trit_t trit;
		logic           last;
	} digit_t;

	localparam int N_DIR        = 24;
	localparam int N_RANDOM     = 96;
	localparam int IDLE_PCT     = 36;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 120;
	localparam int MAX_REPORTS  = 10;
	localparam int PAUSE_A      = N_DIR;
	localparam int PAUSE_B      = N_DIR + 70;
	localparam int CALM_LO      = N_DIR + 30;
	localparam int CALM_HI      = N_DIR + 55;

	localparam stim_row_t DIRECTED [N_DIR] = '{
		'{value: 32'd0,        n_typed: 3'd1, digs: {6'b0, btc_pkg::TRIT_ZERO}},
		'{value: 32'd1,        n_typed: 3'd1, digs: {6'b0, btc_pkg::TRIT_POS}},
		'{value: -32'sd1,      n_typed: 3'd1, digs: {6'b0, btc_pkg::TRIT_NEG}},
		'{value: 32'd2,        n_typed: 3'd2,
			digs: {4'b0, btc_pkg::TRIT_POS, btc_pkg::TRIT_NEG}},
		'{value: -32'sd2,      n_typed: 3'd2,
			digs: {4'b0, btc_pkg::TRIT_NEG, btc_pkg::TRIT_POS}},
		'{value: 32'd3,        n_typed: 3'd2,
			digs: {4'b0, btc_pkg::TRIT_POS, btc_pkg::TRIT_ZERO}},
		'{value: -32'sd3,      n_typed: 3'd2,
			digs: {4'b0, btc_pkg::TRIT_NEG, btc_pkg::TRIT_ZERO}},
		'{value: 32'd4,        n_typed: 3'd2,
			digs: {4'b0, btc_pkg::TRIT_POS, btc_pkg::TRIT_POS}},
		'{value: -32'sd4,      n_typed: 3'd2,
			digs: {4'b0, btc_pkg::TRIT_NEG, btc_pkg::TRIT_NEG}},
		'{value: 32'd8,        n_typed: 3'd3,
			digs: {2'b0, btc_pkg::TRIT_POS, btc_pkg::TRIT_ZERO, btc_pkg::TRIT_NEG}},
		'{value: 32'd9,        n_typed: 3'd3,
			digs: {2'b0, btc_pkg::TRIT_POS, btc_pkg::TRIT_ZERO, btc_pkg::TRIT_ZERO}},
		'{value: 32'd5,        n_typed: 3'd0, digs: 8'h00},
		'{value: -32'sd5,      n_typed: 3'd0, digs: 8'h00},
		'{value: 32'd13,       n_typed: 3'd0, digs: 8'h00},
		'{value: -32'sd13,     n_typed: 3'd0, digs: 8'h00},
		'{value: 32'd1162261467,   n_typed: 3'd0, digs: 8'h00},
		'{value: -32'sd1162261467, n_typed: 3'd0, digs: 8'h00},
		'{value: 32'd1743392200,   n_typed: 3'd0, digs: 8'h00},
		'{value: 32'd1743392201,   n_typed: 3'd0, digs: 8'h00},
		'{value: -32'sd1743392201, n_typed: 3'd0, digs: 8'h00},
		'{value: 32'd2147483647,   n_typed: 3'd0, digs: 8'h00},
		'{value: -32'sd2147483647, n_typed: 3'd0, digs: 8'h00},
		'{value: 32'h5555_5555,    n_typed: 3'd0, digs: 8'h00},
		'{value: 32'hAAAA_AAAA,    n_typed: 3'd0, digs: 8'h00}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;   // [31:0] value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;           // [1:0] trit, [7:2] zero
	logic        m_tlast;

	stim_row_t   value_rows [$];
	digit_t      pending_trits [$];
	stim_row_t   offered_row;
	int          next_row = 0;
	int          digit_errors = 0;
	int          digits_seen = 0;
	int          stall_cycles = 0;
	int          tail_count = 0;
	logic        run_over = 1'b0;
	logic        timed_out = 1'b0;

	balanced_ternary_converter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Balanced ternary digits of one value, queued most significant first.
	function automatic void push_ternary_digits(input logic [31:0] v);
		logic           neg;
		logic [33:0]    mag;
		logic [33:0]    rem;
		btc_pkg::trit_t d;
		btc_pkg::trit_t lsd_first [btc_pkg::MAX_TRITS];
		int             n;
		neg = v[31];
		mag = neg ? {2'b00, -v} : {2'b00, v};
		n = 0;
		if (mag == 34'd0) begin
			pending_trits.push_back('{trit: btc_pkg::TRIT_ZERO, last: 1'b1});
			return;
		end
		while (mag != 34'd0 && n < btc_pkg::MAX_TRITS) begin
			rem = mag % 3;
			mag = mag / 3;
			if (rem == 34'd2) begin
				d = btc_pkg::TRIT_NEG;
				mag = mag + 34'd1;
			end else if (rem == 34'd1) begin
				d = btc_pkg::TRIT_POS;
			end else begin
				d = btc_pkg::TRIT_ZERO;
			end
			// A negative input flips the sign of every digit.
			if (neg && d == btc_pkg::TRIT_POS) begin
				d = btc_pkg::TRIT_NEG;
			end else if (neg && d == btc_pkg::TRIT_NEG) begin
				d = btc_pkg::TRIT_POS;
			end
			lsd_first[n] = d;
			n++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			pending_trits.push_back('{trit: lsd_first[k], last: (k == 0)});
		end
	endfunction

	// Random value drawn from a few shapes that stress digit counts and carries.
	function automatic logic [31:0] pick_value();
		longint p;
		longint v;
		int     k;
		p = 1;
		k = $urandom_range(20, 0);
		for (int i = 0; i < k; i++) begin
			p = p * 3;
		end
		case ($urandom_range(5, 0))
			0: v = $urandom_range(40, 0);
			1: v = longint'($urandom) & 64'h7FFF_FFFF;
			2: v = (k > 19 ? p / 3 : p) + $urandom_range(4, 0) - 2;
			3: v = longint'($urandom) & ((64'd1 << $urandom_range(31, 1)) - 1);
			4: v = (p - 1) / 2 + $urandom_range(2, 0) - 1;
			default: v = 64'd2147483647 - $urandom_range(3, 0);
		endcase
		if (v < 0) begin
			v = 0;
		end
		if (v > 64'd2147483647) begin
			v = 64'd2147483647;
		end
		if ($urandom_range(1, 0) == 1) begin
			v = -v;
		end
		return v[31:0];
	endfunction

	// An idle cycle on either side, except inside the calm stretch.
	function automatic bit take_break();
		return !(next_row >= CALM_LO && next_row < CALM_HI) &&
			($urandom_range(99, 0) < IDLE_PCT);
	endfunction

	// Clock.
	initial begin
		forever #4 clk = ~clk;
	end

	// Both stream sides, the digit check and the watchdog.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			// Check each digit beat against the oldest expectation.
			if (m_tvalid && m_tready) begin
				if (pending_trits.size() == 0) begin
					digit_errors++;
					if (digit_errors <= MAX_REPORTS) begin
						$display("digit beat %0d with nothing expected: tdata %h tlast %b",
							digits_seen, m_tdata, m_tlast);
					end
				end else begin
					digit_t want;
					want = pending_trits.pop_front();
					if (m_tdata !== {6'b0, want.trit} || m_tlast !== want.last) begin
						digit_errors++;
						if (digit_errors <= MAX_REPORTS) begin
							$display("digit beat %0d: tdata exp %h got %h, tlast exp %b got %b",
								digits_seen, {6'b0, want.trit}, m_tdata, want.last, m_tlast);
						end
					end
				end
				digits_seen++;
			end

			// Queue the digits of an accepted value.
			if (s_tvalid && s_tready) begin
				if (offered_row.n_typed != 3'd0) begin
					for (int i = offered_row.n_typed - 1; i >= 0; i--) begin
						pending_trits.push_back('{trit: offered_row.digs[2*i +: 2],
							last: (i == 0)});
					end
				end else begin
					push_ternary_digits(offered_row.value);
				end
			end

			// Offer the next value once the slot is free; drain first at the pauses.
			if (!s_tvalid || s_tready) begin
				if (next_row < value_rows.size() &&
						!((next_row == PAUSE_A || next_row == PAUSE_B) &&
						pending_trits.size() != 0) &&
						!take_break()) begin
					offered_row = value_rows[next_row];
					s_tvalid <= 1'b1;
					s_tdata  <= value_rows[next_row].value;
					next_row++;
				end else begin
					s_tvalid <= 1'b0;
				end
			end

			m_tready <= !take_break();

			// Watchdog on cycles without any beat.
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				timed_out <= 1'b1;
			end

			// Quiet tail once every value is in and every digit is out.
			if (next_row == value_rows.size() && !s_tvalid && pending_trits.size() == 0) begin
				tail_count++;
			end else begin
				tail_count = 0;
			end
			if (tail_count >= TAIL_CYCLES) begin
				run_over <= 1'b1;
			end
		end
	end

	// Stimulus list, reset and the final verdict.
	initial begin
		for (int i = 0; i < N_DIR; i++) begin
			value_rows.push_back(DIRECTED[i]);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			value_rows.push_back('{value: pick_value(), n_typed: 3'd0, digs: 8'h00});
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (!(run_over || timed_out)) begin
			@(negedge clk);
		end
		if (timed_out || digit_errors != 0) begin
			$display("CHECK FAILED");
		end else begin
			$display("CHECK OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/btc_pkg.sv
rtl/core/btc_cell.sv
rtl/core/balanced_ternary_converter_unit.sv
sim/tb_balanced_ternary_converter_unit.sv
